// ===== rtl/mcrr_pkg.sv =====
package mcrr_pkg;

	// default sizes
	localparam int TASK_ENTRIES_DEF = 16;
	localparam int CPU_COUNT_DEF    = 4;

	// fixed field widths
	localparam int OP_W        = 2;
	localparam int CPU_FIELD_W = 8;
	localparam int ENT_FIELD_W = 4;
	localparam int STATUS_W    = 3;
	localparam int S_TDATA_W   = 16;
	localparam int M_TDATA_W   = 24;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 2'd0,
		OP_TICK  = 2'd1,
		OP_START = 2'd2,
		OP_UNDEF = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_WRITTEN     = 3'd0,
		ST_BAD_CPU     = 3'd1,
		ST_NOT_STARTED = 3'd2,
		ST_NONE        = 3'd3,
		ST_KEPT        = 3'd4,
		ST_SWITCHED    = 3'd5,
		ST_STARTED     = 3'd6
	} status_t;

	// run state codes; code 3 may be stored and behaves like other
	localparam logic [1:0] RS_OTHER   = 2'd0;
	localparam logic [1:0] RS_READY   = 2'd1;
	localparam logic [1:0] RS_RUNNING = 2'd2;

	typedef struct packed {
		logic       prim;
		logic [1:0] run_state;
		logic       present;
	} task_entry_t;

	localparam int ENTRY_W = $bits(task_entry_t);

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_DECODE,
		CS_SCAN,
		CS_COMMIT,
		CS_DEMOTE_RD,
		CS_DEMOTE_WR,
		CS_FINISH
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic decode;
		logic scan;
		logic commit;
		logic demote_rd;
		logic demote_wr;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_scan;
		logic hit;
		logic scan_none;
		logic need_demote;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/mcrr_ram.sv =====
module mcrr_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/mcrr_ctrl.sv =====
module mcrr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output mcrr_pkg::cmd_t cmd,
	input  mcrr_pkg::sts_t sts
);

	import mcrr_pkg::*;

	ctrl_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			CS_IDLE: begin
				if (s_tvalid) state_nxt = CS_DECODE;
			end
			CS_DECODE: begin
				state_nxt = sts.need_scan ? CS_SCAN : CS_FINISH;
			end
			CS_SCAN: begin
				if (sts.hit) state_nxt = CS_COMMIT;
				else if (sts.scan_none) state_nxt = CS_FINISH;
			end
			CS_COMMIT: begin
				state_nxt = sts.need_demote ? CS_DEMOTE_RD : CS_FINISH;
			end
			CS_DEMOTE_RD: state_nxt = CS_DEMOTE_WR;
			CS_DEMOTE_WR: state_nxt = CS_FINISH;
			CS_FINISH: begin
				if (sts.out_free) state_nxt = CS_IDLE;
			end
			default: state_nxt = CS_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			CS_IDLE: begin
				s_tready    = 1'b1;
				cmd.load_in = s_tvalid;
			end
			CS_DECODE:    cmd.decode    = 1'b1;
			CS_SCAN:      cmd.scan      = 1'b1;
			CS_COMMIT:    cmd.commit    = 1'b1;
			CS_DEMOTE_RD: cmd.demote_rd = 1'b1;
			CS_DEMOTE_WR: cmd.demote_wr = 1'b1;
			CS_FINISH:    cmd.out_load  = sts.out_free;
			default:      cmd = '0;
		endcase
	end

endmodule

// ===== rtl/mcrr_dp.sv =====
module mcrr_dp #(
	parameter int TASK_ENTRIES = mcrr_pkg::TASK_ENTRIES_DEF,
	parameter int CPU_COUNT    = mcrr_pkg::CPU_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [mcrr_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [mcrr_pkg::OP_W-1:0]      s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [mcrr_pkg::M_TDATA_W-1:0] m_tdata,
	output logic [mcrr_pkg::STATUS_W-1:0]  m_tuser,
	input  mcrr_pkg::cmd_t                 cmd,
	output mcrr_pkg::sts_t                 sts
);

	import mcrr_pkg::*;

	localparam int IDX_W = $clog2(TASK_ENTRIES);
	localparam int SUM_W = IDX_W + 1;
	localparam int CNT_W = $clog2(TASK_ENTRIES + 2);
	localparam int CPU_W = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;

	// captured transaction
	op_t                    op_q;
	logic [CPU_FIELD_W-1:0] cpu_q;
	logic [ENT_FIELD_W-1:0] idx_q;
	task_entry_t            wr_ent_q;

	// scheduler state
	logic [IDX_W-1:0] cursor_q;
	logic             cur_valid_q [CPU_COUNT];
	logic [IDX_W-1:0] cur_entry_q [CPU_COUNT];
	logic             ent_valid_q [TASK_ENTRIES];

	// per-item working registers
	logic [IDX_W-1:0] cur_q;
	logic             cvld_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] pick_q;
	logic             pick_prim_q;
	logic             probe_vld_s1;
	logic [IDX_W-1:0] probe_idx_s1;
	logic             vbit_s1;

	// result and output registers
	status_t                res_status_q;
	logic [ENT_FIELD_W-1:0] res_prev_q;
	logic [ENT_FIELD_W-1:0] res_next_q;
	logic                   res_cvld_q;
	status_t                out_status_q;
	logic [CPU_FIELD_W-1:0] out_cpu_q;
	logic [ENT_FIELD_W-1:0] out_prev_q;
	logic [ENT_FIELD_W-1:0] out_next_q;
	logic                   out_cvld_q;
	logic                   m_tvalid_q;

	// table memory
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	task_entry_t      ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	task_entry_t      ram_rdata;
	task_entry_t      eff;

	logic             in_range;
	logic             bad;
	logic             not_started;
	logic [CPU_W-1:0] cpu_sel;
	logic             slot_vld;
	logic [IDX_W-1:0] slot_ent;
	logic [SUM_W-1:0] scan_sum;
	logic [IDX_W-1:0] scan_addr;
	logic             issue;
	logic             eligible;
	logic             skip_prim;

	mcrr_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TASK_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// decode
	always_comb begin
		in_range    = 32'(idx_q) < TASK_ENTRIES;
		bad         = (op_q == OP_UNDEF) || (32'(cpu_q) >= CPU_COUNT);
		cpu_sel     = CPU_W'(cpu_q);
		slot_vld    = cur_valid_q[cpu_sel];
		slot_ent    = cur_entry_q[cpu_sel];
		not_started = (op_q == OP_TICK) && !slot_vld;
	end

	// scan address: cursor plus offset, wrapped once
	always_comb begin
		scan_sum  = SUM_W'(cursor_q) + SUM_W'(cnt_q);
		scan_addr = (scan_sum >= SUM_W'(TASK_ENTRIES)) ?
			IDX_W'(scan_sum - SUM_W'(TASK_ENTRIES)) : IDX_W'(scan_sum);
		issue     = cmd.scan && (cnt_q <= CNT_W'(TASK_ENTRIES));
		ram_raddr = cmd.demote_rd ? cur_q : scan_addr;
	end

	// an entry never written reads as all zero
	always_comb begin
		eff       = vbit_s1 ? ram_rdata : '0;
		skip_prim = (cpu_q != '0);
		eligible  = eff.present &&
			(eff.run_state == RS_READY || eff.run_state == RS_RUNNING) &&
			!(skip_prim && eff.prim);
	end

	always_comb begin
		sts.need_scan   = (op_q != OP_WRITE) && !bad && !not_started;
		sts.hit         = probe_vld_s1 && eligible;
		sts.scan_none   = (cnt_q == CNT_W'(TASK_ENTRIES + 1)) && !probe_vld_s1;
		sts.need_demote = (op_q == OP_TICK) && (pick_q != cur_q);
		sts.out_free    = !m_tvalid_q || m_tready;
	end

	// single write port
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pick_q;
		ram_wdata = '{prim: pick_prim_q, run_state: RS_RUNNING, present: 1'b1};
		if (cmd.decode && op_q == OP_WRITE && in_range) begin
			ram_we    = 1'b1;
			ram_waddr = IDX_W'(idx_q);
			ram_wdata = wr_ent_q;
		end else if (cmd.commit) begin
			ram_we = 1'b1;
		end else if (cmd.demote_wr && eff.run_state == RS_RUNNING) begin
			ram_we    = 1'b1;
			ram_waddr = cur_q;
			ram_wdata = '{prim: eff.prim, run_state: RS_READY, present: eff.present};
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q     <= IDX_W'(TASK_ENTRIES - 1);
			probe_vld_s1 <= 1'b0;
			m_tvalid_q   <= 1'b0;
			for (int i = 0; i < CPU_COUNT; i++) begin
				cur_valid_q[i] <= 1'b0;
				cur_entry_q[i] <= '0;
			end
			for (int i = 0; i < TASK_ENTRIES; i++) begin
				ent_valid_q[i] <= 1'b0;
			end
		end else begin
			probe_vld_s1 <= issue;
			if (ram_we) ent_valid_q[ram_waddr] <= 1'b1;
			if (cmd.commit) begin
				cursor_q             <= pick_q;
				cur_valid_q[cpu_sel] <= 1'b1;
				cur_entry_q[cpu_sel] <= pick_q;
			end
			if (cmd.out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q     <= op_t'(s_tuser);
			cpu_q    <= s_tdata[7:0];
			idx_q    <= s_tdata[11:8];
			wr_ent_q <= '{prim: s_tdata[15], run_state: s_tdata[14:13],
				present: s_tdata[12]};
		end

		probe_idx_s1 <= scan_addr;
		vbit_s1      <= ent_valid_q[ram_raddr];
		if (issue) cnt_q <= cnt_q + CNT_W'(1);

		if (cmd.decode) begin
			cnt_q        <= CNT_W'(1);
			cur_q        <= slot_vld ? slot_ent : '0;
			cvld_q       <= slot_vld;
			res_prev_q   <= '0;
			res_next_q   <= '0;
			res_cvld_q   <= 1'b0;
			if (op_q == OP_WRITE) res_status_q <= ST_WRITTEN;
			else if (bad) res_status_q <= ST_BAD_CPU;
			else res_status_q <= ST_NOT_STARTED;
		end

		if (cmd.scan && sts.hit) begin
			pick_q      <= probe_idx_s1;
			pick_prim_q <= eff.prim;
		end
		if (cmd.scan && sts.scan_none) begin
			res_status_q <= ST_NONE;
			res_prev_q   <= ENT_FIELD_W'(cur_q);
			res_next_q   <= ENT_FIELD_W'(cur_q);
			res_cvld_q   <= cvld_q;
		end

		if (cmd.commit) begin
			res_prev_q <= ENT_FIELD_W'(cur_q);
			res_next_q <= ENT_FIELD_W'(pick_q);
			res_cvld_q <= 1'b1;
			if (op_q == OP_START) res_status_q <= ST_STARTED;
			else if (pick_q == cur_q) res_status_q <= ST_KEPT;
			else res_status_q <= ST_SWITCHED;
		end

		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_cpu_q    <= cpu_q;
			out_prev_q   <= res_prev_q;
			out_next_q   <= res_next_q;
			out_cvld_q   <= res_cvld_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {7'd0, out_cvld_q, out_next_q, out_prev_q, out_cpu_q};

endmodule

// ===== rtl/multi_cpu_round_robin_scheduler.sv =====
// round-robin task scheduler for several cpus. each input transaction carries an
// operation in s_tuser: write a task table entry, tick/yield a cpu, or start/join
// a cpu. every input transaction produces exactly one result transaction, with a
// status code in m_tuser. ticks and starts scan the table from the shared cursor
// plus one, wrapping, and take the first present entry that is ready or running
// (cpus other than 0 skip primary-only entries). the block works on one
// transaction at a time: a write, a rejected cpu or a tick before start goes from
// decode straight to the result; a scan reads one table entry per cycle through
// the registered table read, then commits, and a tick that switches tasks also
// reads back and demotes the old task. the scan rate is set by the single read
// port of the task table memory. a new input transaction is taken while a
// finished result still waits on the output register. the table comes out of
// reset empty through per-entry written flags, so there is no clearing pass and
// the block is ready right after reset.
module multi_cpu_round_robin_scheduler #(
	parameter int TASK_ENTRIES = mcrr_pkg::TASK_ENTRIES_DEF,
	parameter int CPU_COUNT    = mcrr_pkg::CPU_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input transaction
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// cpu[7:0], entry_index[11:8], entry_present_in[12], entry_state_in[14:13],
	// entry_primary_only_in[15]
	input  logic [mcrr_pkg::S_TDATA_W-1:0] s_tdata,
	// op[1:0]
	input  logic [mcrr_pkg::OP_W-1:0]      s_tuser,
	// result transaction
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// cpu_out[7:0], prev_entry[11:8], next_entry[15:12], current_valid[16],
	// zero fill above
	output logic [mcrr_pkg::M_TDATA_W-1:0] m_tdata,
	// status[2:0]
	output logic [mcrr_pkg::STATUS_W-1:0]  m_tuser
);

	import mcrr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing: accept, decode, scan, commit, demote, hand off
	mcrr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.cmd     (cmd),
		.sts     (sts)
	);

	// task table, cursor, per-cpu slots and the output register
	mcrr_dp #(
		.TASK_ENTRIES(TASK_ENTRIES),
		.CPU_COUNT   (CPU_COUNT)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.cmd     (cmd),
		.sts     (sts)
	);

endmodule

// ===== sim/sched_checker.sv =====
`timescale 1ns / 100ps

// watches both channels, predicts each result and compares it on arrival
module sched_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [mcrr_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [mcrr_pkg::OP_W-1:0]      s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [mcrr_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic [mcrr_pkg::STATUS_W-1:0]  m_tuser,
	output int                             fail_count,
	output int                             pending
);

	import mcrr_pkg::*;

	typedef struct packed {
		status_t    status;
		logic [7:0] cpu;
		logic [3:0] prev_entry;
		logic [3:0] next_entry;
		logic       current_valid;
	} sched_result_t;

	// shadow copy of the scheduler state
	logic       task_here [TASK_ENTRIES_DEF];
	logic [1:0] task_state [TASK_ENTRIES_DEF];
	logic       task_prim [TASK_ENTRIES_DEF];
	logic [3:0] rr_cursor;
	logic       slot_valid [CPU_COUNT_DEF];
	logic [3:0] slot_entry [CPU_COUNT_DEF];

	sched_result_t expected_results[$];

	// round-robin search from cursor + 1; moves the cursor on a hit
	function automatic logic find_next_task(logic skip_prim, output logic [3:0] pick);
		logic [3:0] idx;
		pick = '0;
		for (int i = 1; i <= TASK_ENTRIES_DEF; i++) begin
			idx = rr_cursor + 4'(i);
			if (task_here[idx] && (task_state[idx] == RS_READY || task_state[idx] == RS_RUNNING)
					&& !(skip_prim && task_prim[idx])) begin
				rr_cursor = idx;
				pick = idx;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic sched_result_t schedule_step(op_t op, logic [7:0] cpu, logic [3:0] idx,
			logic here, logic [1:0] state, logic prim);
		sched_result_t r;
		logic [3:0] cur, pick;
		int c;
		r = '{status: ST_WRITTEN, cpu: cpu, prev_entry: 4'd0, next_entry: 4'd0,
			current_valid: 1'b0};
		if (op == OP_WRITE) begin
			task_here[idx] = here;
			task_state[idx] = state;
			task_prim[idx] = prim;
			return r;
		end
		if (op == OP_UNDEF || cpu >= CPU_COUNT_DEF) begin
			r.status = ST_BAD_CPU;
			return r;
		end
		c = int'(cpu);
		if (op == OP_TICK) begin
			if (!slot_valid[c]) begin
				r.status = ST_NOT_STARTED;
				return r;
			end
			cur = slot_entry[c];
			r.prev_entry = cur;
			r.next_entry = cur;
			r.current_valid = 1'b1;
			if (!find_next_task(c != 0, pick)) begin
				r.status = ST_NONE;
			end else if (pick == cur) begin
				task_state[cur] = RS_RUNNING;
				r.status = ST_KEPT;
			end else begin
				if (task_state[cur] == RS_RUNNING)
					task_state[cur] = RS_READY;
				task_state[pick] = RS_RUNNING;
				slot_entry[c] = pick;
				r.next_entry = pick;
				r.status = ST_SWITCHED;
			end
			return r;
		end
		// start or join
		cur = slot_valid[c] ? slot_entry[c] : 4'd0;
		r.prev_entry = cur;
		r.next_entry = cur;
		r.current_valid = slot_valid[c];
		if (!find_next_task(c != 0, pick)) begin
			r.status = ST_NONE;
			return r;
		end
		slot_valid[c] = 1'b1;
		slot_entry[c] = pick;
		task_state[pick] = RS_RUNNING;
		r.status = ST_STARTED;
		r.next_entry = pick;
		r.current_valid = 1'b1;
		return r;
	endfunction

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		sched_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < TASK_ENTRIES_DEF; i++) begin
				task_here[i] = 1'b0;
				task_state[i] = RS_OTHER;
				task_prim[i] = 1'b0;
			end
			for (int i = 0; i < CPU_COUNT_DEF; i++) begin
				slot_valid[i] = 1'b0;
				slot_entry[i] = 4'd0;
			end
			rr_cursor = 4'(TASK_ENTRIES_DEF - 1);
			expected_results.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("result transaction with nothing expected, status %0d", m_tuser);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("status", want.status, m_tuser);
					check_field("cpu_out", want.cpu, m_tdata[7:0]);
					check_field("prev_entry", want.prev_entry, m_tdata[11:8]);
					check_field("next_entry", want.next_entry, m_tdata[15:12]);
					check_field("current_valid", want.current_valid, m_tdata[16]);
					check_field("tdata fill", 0, m_tdata[M_TDATA_W-1:17]);
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(schedule_step(op_t'(s_tuser), s_tdata[7:0],
					s_tdata[11:8], s_tdata[12], s_tdata[14:13], s_tdata[15]));
			pending <= expected_results.size();
		end
	end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import mcrr_pkg::*;

	// cycles without any transaction before the run is declared hung
	localparam int HANG_LIMIT = 4000;
	// run state code 3 is storable but never eligible
	localparam logic [1:0] RS_UNUSED = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [OP_W-1:0]      s_tuser = OP_WRITE;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]  m_tuser;

	int  fail_count;
	int  pending;
	int  idle_cycles = 0;
	// quiet phases turn off random gaps on one side
	bit  send_quiet = 1'b0;
	bit  recv_quiet = 1'b0;

	always #4 clk = ~clk;

	multi_cpu_round_robin_scheduler dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	sched_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// one input transaction: random gap, then hold valid until the handshake
	task automatic send_item(op_t op, logic [7:0] cpu, logic [3:0] idx, logic here,
			logic [1:0] state, logic prim);
		int gap;
		gap = send_quiet ? 0 : $urandom_range(0, 8);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {prim, state, here, idx, cpu};
		do @(posedge clk); while (!s_tready);
	endtask

	// hold off the sender until every outstanding result is back
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// mostly table writes, ticks and starts on real cpus; the rest is noise
	task automatic random_item();
		int pick;
		logic [7:0] cpu;
		logic [1:0] state;
		pick = $urandom_range(0, 99);
		cpu = 8'($urandom_range(0, CPU_COUNT_DEF - 1));
		state = ($urandom_range(0, 4) != 0) ? 2'($urandom_range(RS_READY, RS_RUNNING))
			: 2'($urandom);
		if (pick < 30)
			send_item(OP_WRITE, 8'($urandom), 4'($urandom), $urandom_range(0, 4) != 0, state,
				$urandom_range(0, 3) == 0);
		else if (pick < 70)
			send_item(OP_TICK, cpu, 4'($urandom), 1'($urandom), 2'($urandom), 1'($urandom));
		else if (pick < 88)
			send_item(OP_START, cpu, 4'($urandom), 1'($urandom), 2'($urandom), 1'($urandom));
		else if (pick < 94)
			send_item(op_t'($urandom_range(OP_TICK, OP_START)),
				8'($urandom_range(CPU_COUNT_DEF, 255)), 4'($urandom), 1'($urandom),
				2'($urandom), 1'($urandom));
		else
			send_item(OP_UNDEF, 8'($urandom), 4'($urandom), 1'($urandom), 2'($urandom),
				1'($urandom));
	endtask

	// result side: random stall before each result, none in quiet phases
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				stall = recv_quiet ? 0 : $urandom_range(0, 8);
			@(negedge clk);
			if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// hang detection: any transaction on either side resets the count
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= HANG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// tick before start, empty-table start, undefined op, rejected cpus
		send_item(OP_TICK,  8'd0,   4'd0,  1'b0, RS_OTHER,   1'b0);
		send_item(OP_START, 8'd0,   4'd0,  1'b0, RS_OTHER,   1'b0);
		send_item(OP_UNDEF, 8'hff,  4'hf,  1'b1, RS_UNUSED,  1'b1);
		send_item(OP_TICK,  8'hff,  4'd0,  1'b0, RS_OTHER,   1'b0);
		send_item(OP_START, 8'd4,   4'd0,  1'b0, RS_OTHER,   1'b0);
		// code 3 entry, primary-only entry at the top, one ready, one absent
		send_item(OP_WRITE, 8'hff,  4'd0,  1'b1, RS_UNUSED,  1'b0);
		send_item(OP_WRITE, 8'd0,   4'd15, 1'b1, RS_READY,   1'b1);
		send_item(OP_WRITE, 8'd7,   4'd5,  1'b1, RS_READY,   1'b0);
		send_item(OP_WRITE, 8'd0,   4'd9,  1'b0, RS_READY,   1'b0);
		// cpu 0 starts, cpu 1 joins on the same task past the primary-only one
		send_item(OP_START, 8'd0,   4'd0,  1'b0, RS_OTHER,   1'b0);
		send_item(OP_START, 8'd1,   4'd0,  1'b0, RS_OTHER,   1'b0);
		// cpu 0 switches to the primary-only task, cpu 1 keeps its own
		send_item(OP_TICK,  8'd0,   4'd0,  1'b0, RS_OTHER,   1'b0);
		send_item(OP_TICK,  8'd1,   4'd0,  1'b0, RS_OTHER,   1'b0);
		send_item(OP_TICK,  8'd2,   4'd0,  1'b0, RS_OTHER,   1'b0);
		send_item(OP_START, 8'd3,   4'd0,  1'b0, RS_OTHER,   1'b0);
		// restart of a started cpu, then its current entry goes stale
		send_item(OP_START, 8'd0,   4'd0,  1'b0, RS_OTHER,   1'b0);
		send_item(OP_WRITE, 8'd0,   4'd15, 1'b0, RS_OTHER,   1'b0);
		send_item(OP_TICK,  8'd0,   4'd0,  1'b0, RS_OTHER,   1'b0);
		// block the last task: nothing eligible for ticks and starts
		send_item(OP_WRITE, 8'd0,   4'd5,  1'b1, RS_OTHER,   1'b0);
		send_item(OP_TICK,  8'd1,   4'd0,  1'b0, RS_OTHER,   1'b0);
		send_item(OP_START, 8'd2,   4'd0,  1'b0, RS_OTHER,   1'b0);
		// running primary-only task: cpu 0 takes it, cpu 3 cannot
		send_item(OP_WRITE, 8'ha5,  4'd3,  1'b1, RS_RUNNING, 1'b1);
		send_item(OP_TICK,  8'd0,   4'd0,  1'b0, RS_OTHER,   1'b0);
		send_item(OP_TICK,  8'd3,   4'd0,  1'b0, RS_OTHER,   1'b0);
		send_item(OP_WRITE, 8'h5a,  4'd10, 1'b1, RS_READY,   1'b0);
		send_item(OP_TICK,  8'd3,   4'd0,  1'b0, RS_OTHER,   1'b0);
		drain_results();

		for (int n = 0; n < 600; n++) begin
			if ($urandom_range(0, 39) == 0)
				send_quiet = !send_quiet;
			if ($urandom_range(0, 39) == 0)
				recv_quiet = !recv_quiet;
			if (n % 150 == 75)
				drain_results();
			random_item();
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		// wait out the outstanding results, then a margin for stray ones
		do @(posedge clk); while (pending != 0);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== multi_cpu_round_robin_scheduler.f =====
rtl/mcrr_pkg.sv
rtl/mcrr_ram.sv
rtl/mcrr_ctrl.sv
rtl/mcrr_dp.sv
rtl/multi_cpu_round_robin_scheduler.sv
sim/sched_checker.sv
sim/tb.sv
